/* hdl/rs_pkg.sv */
// ----------------------------------------------------------------------------
// rs_pkg
// Shared types and constants for the rectangle subtract block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rs_pkg;

  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int ARITH_BITS = COORD_BITS + 2;
  localparam int SLOTS      = 4;

  // candidate piece slots, in emission order
  localparam int SLOT_TOP    = 0;
  localparam int SLOT_BOTTOM = 1;
  localparam int SLOT_LEFT   = 2;
  localparam int SLOT_RIGHT  = 3;

  typedef logic signed [ARITH_BITS-1:0] arith_t;

  typedef enum logic [1:0] {
    OUT_PIECE    = 2'd0,
    OUT_COVERED  = 2'd1,
    OUT_DISJOINT = 2'd2
  } outcome_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic        [SIZE_BITS-1:0]  first_width;
    logic        [SIZE_BITS-1:0]  first_height;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic        [SIZE_BITS-1:0]  second_width;
    logic        [SIZE_BITS-1:0]  second_height;
  } req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] piece_x;
    logic signed [COORD_BITS-1:0] piece_y;
    logic        [SIZE_BITS-1:0]  piece_width;
    logic        [SIZE_BITS-1:0]  piece_height;
    outcome_t                     outcome;
    logic        [2:0]            piece_total;
    logic                         last_piece;
  } res_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic        [SIZE_BITS-1:0]  w;
    logic        [SIZE_BITS-1:0]  h;
  } piece_t;

  // decomposed result of one subtraction
  typedef struct packed {
    piece_t [SLOTS-1:0] piece;
    logic   [SLOTS-1:0] mask;
    logic   [2:0]       total;
    logic               disjoint;
  } set_t;

endpackage

`default_nettype wire

/* hdl/rectangle_subtract_top.sv */
// ----------------------------------------------------------------------------
// rectangle_subtract_top
// Axis-aligned rectangle difference: the pieces of first not covered by second.
//
// A request transfers at a rising edge with start high and busy low. It sits in
// the input register, is decomposed combinationally into up to four pieces that
// load the piece buffer, and the sequencer then sends one piece per cycle.
// Each result is on result for one cycle with strobe high; the receiver
// cannot stall. Pieces come out top, bottom, left, right; the final one has
// last_piece set. When nothing remains a single result with outcome covered
// or disjoint and zero geometry is sent.
// A request passes the input register and the piece buffer before its first
// result is registered. The input register can hold the next request while the
// buffer emits; it enters the buffer in the cycle the last piece leaves.
// Reset (synchronous) drops any request in flight and clears strobe and busy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rectangle_subtract_top (
  input  wire          clk,
  input  wire          rst,
  input  wire          start,
  output logic         busy,
  input  rs_pkg::req_t request,
  output logic         strobe,
  output rs_pkg::res_t result
);
  import rs_pkg::*;

  req_t held_req;
  logic held_valid;
  logic emit_ready;
  logic take;
  set_t set;

  assign busy = held_valid && !emit_ready;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (emit_ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_req <= request;
    end
  end

  rs_calc u_calc (
    .request (held_req),
    .set     (set)
  );

  rs_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .set_valid (held_valid),
    .set       (set),
    .ready     (emit_ready),
    .strobe    (strobe),
    .result    (result)
  );

endmodule

`default_nettype wire

/* hdl/rs_calc.sv */
// ----------------------------------------------------------------------------
// rs_calc
// Corner tests and piece geometry for one rectangle pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rs_calc (
  input  rs_pkg::req_t request,
  output rs_pkg::set_t set
);
  import rs_pkg::*;

  localparam arith_t ONE = arith_t'(1);

  function automatic logic contains(arith_t rx, arith_t ry, arith_t rxe, arith_t rye,
                                    arith_t px, arith_t py);
    return (px >= rx) && (px < rxe) && (py >= ry) && (py < rye);
  endfunction

  arith_t ax, ay, aw, ah, bx, by, bw, bh;
  arith_t axe, aye, bxe, bye, axl, ayl, bxl, byl;
  logic   p1, p2, p3, p4, q1, q2, q3, q4;
  logic   top, right, bottom, left, general, vcross, hcross;
  logic   [SLOTS-1:0] en;
  logic   disjoint;
  arith_t sy, sh;
  arith_t px [SLOTS];
  arith_t py [SLOTS];
  arith_t pw [SLOTS];
  arith_t ph [SLOTS];

  assign ax  = arith_t'(request.first_x);
  assign ay  = arith_t'(request.first_y);
  assign aw  = arith_t'(request.first_width);
  assign ah  = arith_t'(request.first_height);
  assign bx  = arith_t'(request.second_x);
  assign by  = arith_t'(request.second_y);
  assign bw  = arith_t'(request.second_width);
  assign bh  = arith_t'(request.second_height);

  assign axe = ax + aw;
  assign aye = ay + ah;
  assign bxe = bx + bw;
  assign bye = by + bh;
  assign axl = axe - ONE;
  assign ayl = aye - ONE;
  assign bxl = bxe - ONE;
  assign byl = bye - ONE;

  assign p1 = contains(ax, ay, axe, aye, bx,  by);
  assign p2 = contains(ax, ay, axe, aye, bxl, by);
  assign p3 = contains(ax, ay, axe, aye, bxl, byl);
  assign p4 = contains(ax, ay, axe, aye, bx,  byl);
  assign q1 = contains(bx, by, bxe, bye, ax,  ay);
  assign q2 = contains(bx, by, bxe, bye, axl, ay);
  assign q3 = contains(bx, by, bxe, bye, axl, ayl);
  assign q4 = contains(bx, by, bxe, bye, ax,  ayl);

  assign top     = p1 || p2;
  assign right   = p2 || p3;
  assign bottom  = p3 || p4;
  assign left    = p4 || p1;
  assign general = top || right || bottom || left;

  assign vcross = (bx >= ax) && (bx < axe) && (by < ay) && (bye >= aye);
  assign hcross = (by >= ay) && (by < aye) && (bx < ax) && (bxe >= axe);

  always_comb begin
    en       = '0;
    disjoint = 1'b0;
    sy       = ay;
    sh       = ah;
    if (general) begin
      en[SLOT_TOP]    = top;
      en[SLOT_BOTTOM] = bottom;
      en[SLOT_LEFT]   = left;
      en[SLOT_RIGHT]  = right;
      sy = top ? by : ay;
      priority if (top && bottom) begin
        sh = bh;
      end else if (bottom) begin
        sh = bye - sy;
      end else begin
        sh = aye - sy;
      end
    end else begin
      priority if (q1 && q2 && q3 && q4) begin
        en = '0;
      end else if (!q1 && !q2 && !q3 && !q4) begin
        priority if (!vcross && !hcross) begin
          disjoint = 1'b1;
        end else if (ah > bh) begin
          en[SLOT_TOP]    = 1'b1;
          en[SLOT_BOTTOM] = 1'b1;
        end else begin
          en[SLOT_LEFT]   = 1'b1;
          en[SLOT_RIGHT]  = 1'b1;
        end
      end else if (q1 && q4) begin
        en[SLOT_RIGHT] = 1'b1;
      end else if (q2 && q3) begin
        en[SLOT_LEFT] = 1'b1;
      end else if (q1 && q2) begin
        en[SLOT_BOTTOM] = 1'b1;
      end else begin
        en[SLOT_TOP] = 1'b1;
      end
    end
  end

  always_comb begin
    px[SLOT_TOP]    = ax;
    py[SLOT_TOP]    = ay;
    pw[SLOT_TOP]    = aw;
    ph[SLOT_TOP]    = by - ay;
    px[SLOT_BOTTOM] = ax;
    py[SLOT_BOTTOM] = bye;
    pw[SLOT_BOTTOM] = aw;
    ph[SLOT_BOTTOM] = aye - bye;
    px[SLOT_LEFT]   = ax;
    py[SLOT_LEFT]   = sy;
    pw[SLOT_LEFT]   = bx - ax;
    ph[SLOT_LEFT]   = sh;
    px[SLOT_RIGHT]  = bxe;
    py[SLOT_RIGHT]  = sy;
    pw[SLOT_RIGHT]  = axe - bxe;
    ph[SLOT_RIGHT]  = sh;
  end

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      set.mask[k]    = en[k] && (pw[k] > arith_t'(0)) && (ph[k] > arith_t'(0));
      set.piece[k].x = px[k][COORD_BITS-1:0];
      set.piece[k].y = py[k][COORD_BITS-1:0];
      set.piece[k].w = pw[k][SIZE_BITS-1:0];
      set.piece[k].h = ph[k][SIZE_BITS-1:0];
    end
    set.total    = 3'($countones(set.mask));
    set.disjoint = disjoint;
  end

endmodule

`default_nettype wire

/* hdl/rs_emit.sv */
// ----------------------------------------------------------------------------
// rs_emit
// Piece buffer and output sequencer: one piece per cycle, lowest slot first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rs_emit (
  input  wire          clk,
  input  wire          rst,
  input  wire          set_valid,
  input  rs_pkg::set_t set,
  output logic         ready,
  output logic         strobe,
  output rs_pkg::res_t result
);
  import rs_pkg::*;

  function automatic logic [1:0] lowest(logic [SLOTS-1:0] m);
    logic [1:0] idx;
    idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (m[k]) idx = 2'(k);
    end
    return idx;
  endfunction

  set_t             held;
  logic             held_valid;
  logic [SLOTS-1:0] rem;
  logic [SLOTS-1:0] rem_next;
  logic [1:0]       sel;
  logic             last_now;
  logic             load;
  res_t             result_next;

  assign sel      = lowest(rem);
  assign rem_next = rem & (rem - SLOTS'(1));
  assign last_now = held_valid && (rem_next == '0);
  assign ready    = !held_valid || last_now;
  assign load     = set_valid && ready;

  always_comb begin
    if (held.mask == '0) begin
      result_next.piece_x      = '0;
      result_next.piece_y      = '0;
      result_next.piece_width  = '0;
      result_next.piece_height = '0;
      result_next.outcome      = held.disjoint ? OUT_DISJOINT : OUT_COVERED;
      result_next.piece_total  = '0;
      result_next.last_piece   = 1'b1;
    end else begin
      result_next.piece_x      = held.piece[sel].x;
      result_next.piece_y      = held.piece[sel].y;
      result_next.piece_width  = held.piece[sel].w;
      result_next.piece_height = held.piece[sel].h;
      result_next.outcome      = OUT_PIECE;
      result_next.piece_total  = held.total;
      result_next.last_piece   = last_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= held_valid;
      if (load) begin
        held_valid <= 1'b1;
      end else if (last_now) begin
        held_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= set;
      rem  <= set.mask;
    end else begin
      rem  <= rem_next;
    end
    if (held_valid) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/rs_checker.sv */
// ----------------------------------------------------------------------------
// rs_checker
// Port-level checks on the result stream of rectangle_subtract_top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rs_checker (
  input wire          clk,
  input wire          rst,
  input wire          strobe,
  input rs_pkg::res_t result
);
  import rs_pkg::*;

  // reset clears the output strobe
  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe)
    else $error("strobe after reset");

  // pieces of one request leave in consecutive cycles
  a_pieces_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last_piece) |=> strobe)
    else $error("gap inside piece sequence");

  a_total_stable: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last_piece) |=> (result.piece_total == $past(result.piece_total)))
    else $error("piece_total changed within a request");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.outcome != OUT_PIECE) |->
      (result.last_piece && result.piece_total == 3'd0 &&
       result.piece_width == '0 && result.piece_height == '0))
    else $error("malformed covered/disjoint result");

  a_piece_total: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.outcome == OUT_PIECE) |->
      (result.piece_total != 3'd0 && result.piece_total <= 3'd4 &&
       result.piece_width != '0 && result.piece_height != '0))
    else $error("bad piece result");

endmodule

bind rectangle_subtract_top rs_checker u_rs_checker (
  .clk    (clk),
  .rst    (rst),
  .strobe (strobe),
  .result (result)
);

`default_nettype wire
